@@ src/afrc_pkg.sv @@
// Shared types, codes and decode helpers for the ASCII frame receiver.
package afrc_pkg;

    localparam logic [1:0] MODE_BYTE  = 2'd0;
    localparam logic [1:0] MODE_TICK  = 2'd1;
    localparam logic [1:0] MODE_START = 2'd2;

    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_MISMATCH  = 3'd1;
    localparam logic [2:0] STATUS_TIMEOUT   = 3'd2;
    localparam logic [2:0] STATUS_TOO_SHORT = 3'd3;
    localparam logic [2:0] STATUS_TOO_LONG  = 3'd4;

    localparam logic KIND_BODY    = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic [7:0]  START_BYTE     = 8'h7E;
    localparam logic [7:0]  END_BYTE       = 8'h0D;
    localparam logic [7:0]  MAX_FRAME_LEN  = 8'd255;
    localparam logic [15:0] TIMEOUT_RESET  = 16'd500;
    localparam logic [7:0]  MIN_FRAME_LEN  = 8'd4;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  body_byte;
        logic [2:0]  status;
        logic [15:0] computed_sum;
        logic [15:0] received_sum;
        logic [7:0]  body_count;
    } res_t;

    function automatic logic [7:0] hex_nibble(input logic [7:0] c);
        logic [7:0] v;
        if (c <= 8'h39) begin
            v = c - 8'h30;
        end else begin
            v = {5'd0, c[2:0]} + 8'd9;
        end
        return v;
    endfunction

    function automatic logic [7:0] hex_pair(input logic [7:0] hi, input logic [7:0] lo);
        logic [7:0] h;
        logic [7:0] l;
        h = hex_nibble(hi);
        l = hex_nibble(lo);
        return {h[3:0], 4'd0} + l;
    endfunction

endpackage

@@ src/afrc_in.sv @@
// Input register stage that holds one accepted beat until the core takes it.
module afrc_in (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  afrc_pkg::item_t s_item,
    input  logic            slot_free,
    output logic            advance,
    output afrc_pkg::item_t item
);
    import afrc_pkg::*;

    logic  in_vld_reg;
    logic  in_vld_next;
    item_t item_reg;

    assign advance = in_vld_reg && slot_free;
    assign s_ready = !in_vld_reg || slot_free;
    assign item    = item_reg;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_valid && s_ready) begin
            in_vld_next = 1'b1;
        end else if (advance) begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else begin
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    a_hold_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && !advance |=> in_vld_reg && $stable(item_reg))
        else $error("Held input beat changed while stalled.");

endmodule

@@ src/afrc_core.sv @@
// Frame state, tick timer, running sum and checksum verdict logic.
module afrc_core (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_wr,
    input  logic [15:0]     cfg_data,
    input  logic            advance,
    input  afrc_pkg::item_t item,
    output logic            res_load,
    output afrc_pkg::res_t  res
);
    import afrc_pkg::*;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_HUNT  = 2'd1;
    localparam logic [1:0] PH_FRAME = 2'd2;

    logic [15:0] timeout_reg;
    logic [1:0]  phase_reg;
    logic [1:0]  phase_next;
    logic [15:0] elapsed_reg;
    logic [15:0] elapsed_next;
    logic [7:0]  count_reg;
    logic [7:0]  count_next;
    logic [15:0] sum_reg;
    logic [15:0] sum_next;
    logic [7:0]  tail_reg [4];
    logic [7:0]  tail_next [4];
    logic [16:0] tick_count;
    logic [9:0]  tail_sum;
    logic [15:0] body_sum;
    logic [15:0] comp_sum;
    logic [15:0] recv_sum;
    logic        has_res;
    res_t        res_c;

    assign tick_count = {1'b0, elapsed_reg} + 17'd1;
    assign tail_sum   = {2'd0, tail_reg[0]} + {2'd0, tail_reg[1]}
                      + {2'd0, tail_reg[2]} + {2'd0, tail_reg[3]};
    assign body_sum   = sum_reg - {6'd0, tail_sum};
    assign comp_sum   = 16'd0 - body_sum;
    assign recv_sum   = {hex_pair(tail_reg[0], tail_reg[1]),
                         hex_pair(tail_reg[2], tail_reg[3])};

    always_comb begin
        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        tail_next    = tail_reg;
        has_res      = 1'b0;
        res_c        = '0;
        unique case (item.mode)
            MODE_START: begin
                phase_next   = PH_HUNT;
                elapsed_next = '0;
                count_next   = '0;
                sum_next     = '0;
                tail_next    = '{default: '0};
            end
            MODE_TICK: begin
                if (phase_reg != PH_IDLE) begin
                    if (tick_count > {1'b0, timeout_reg}) begin
                        phase_next       = PH_IDLE;
                        has_res          = 1'b1;
                        res_c.kind       = KIND_VERDICT;
                        res_c.status     = STATUS_TIMEOUT;
                        res_c.body_count = count_reg;
                    end else begin
                        elapsed_next = tick_count[16] ? 16'hFFFF : tick_count[15:0];
                    end
                end
            end
            MODE_BYTE: begin
                if (phase_reg == PH_HUNT) begin
                    if (item.rx_byte == START_BYTE) begin
                        phase_next = PH_FRAME;
                    end
                end else if (phase_reg == PH_FRAME) begin
                    if (item.rx_byte == END_BYTE) begin
                        phase_next       = PH_IDLE;
                        has_res          = 1'b1;
                        res_c.kind       = KIND_VERDICT;
                        res_c.body_count = count_reg;
                        if (count_reg < MIN_FRAME_LEN) begin
                            res_c.status = STATUS_TOO_SHORT;
                        end else begin
                            res_c.computed_sum = comp_sum;
                            res_c.received_sum = recv_sum;
                            res_c.status = (comp_sum == recv_sum) ? STATUS_OK
                                                                  : STATUS_MISMATCH;
                        end
                    end else if (count_reg >= MAX_FRAME_LEN) begin
                        phase_next       = PH_IDLE;
                        has_res          = 1'b1;
                        res_c.kind       = KIND_VERDICT;
                        res_c.status     = STATUS_TOO_LONG;
                        res_c.body_count = count_reg;
                    end else begin
                        count_next      = count_reg + 8'd1;
                        sum_next        = sum_reg + {8'd0, item.rx_byte};
                        tail_next[0]    = tail_reg[1];
                        tail_next[1]    = tail_reg[2];
                        tail_next[2]    = tail_reg[3];
                        tail_next[3]    = item.rx_byte;
                        has_res         = 1'b1;
                        res_c.kind      = KIND_BODY;
                        res_c.body_byte = item.rx_byte;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign res_load = advance && has_res;
    assign res      = res_c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_wr) begin
            timeout_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            elapsed_reg <= '0;
            count_reg   <= '0;
            sum_reg     <= '0;
            tail_reg    <= '{default: '0};
        end else if (advance) begin
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            tail_reg    <= tail_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MAX_FRAME_LEN)
        else $error("Body byte count exceeded the frame limit.");

    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && phase_reg == PH_IDLE && item.mode != MODE_START |-> !res_load)
        else $error("Result produced while idle.");

    a_body_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load && res.kind == KIND_BODY |-> res.status == STATUS_OK
            && res.computed_sum == 16'd0 && res.body_count == 8'd0)
        else $error("Body beat carries verdict fields.");

endmodule

@@ src/afrc_out.sv @@
// Result register that holds one result beat until the receiver takes it.
module afrc_out (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           res_load,
    input  afrc_pkg::res_t res,
    output logic           slot_free,
    output logic           m_valid,
    input  logic           m_ready,
    output afrc_pkg::res_t m_res
);
    import afrc_pkg::*;

    logic res_vld_reg;
    logic res_vld_next;
    res_t res_reg;

    assign slot_free = !res_vld_reg || m_ready;
    assign m_valid   = res_vld_reg;
    assign m_res     = res_reg;

    always_comb begin
        res_vld_next = res_vld_reg;
        if (res_load) begin
            res_vld_next = 1'b1;
        end else if (m_ready) begin
            res_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_vld_reg <= 1'b0;
        end else begin
            res_vld_reg <= res_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_load) begin
            res_reg <= res;
        end
    end

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        res_load |-> !res_vld_reg || m_ready)
        else $error("Result register overwritten before it was taken.");

endmodule

@@ src/ascii_frame_receiver_checksum.sv @@
// Top level of the ASCII hex frame receiver with two's-complement sum check.
//
// The input channel (s_valid/s_ready) carries one beat per byte, tick or start
// command, selected by s_mode. The result channel (m_valid/m_ready) carries at
// most one beat per input beat: a body byte passed through, or a verdict with
// status, computed and received checksum and body byte count.
// The configuration channel (cfg_valid/cfg_ready/cfg_data) writes the timeout
// in ticks; it is always ready and should be written only while idle.
// An input beat lands in an input register and is processed once the result
// register is free; its result is then loaded into the result register, which
// drives m_valid. One input beat can be accepted in every cycle while the result
// channel does not stall, set by the single pass from input to result register.
// While a result waits for m_ready, the input register still takes one beat;
// after that s_ready drops until the result is taken.
// Reset clears both registers, returns the receiver to idle and loads the
// timeout with 500 ticks.
module ascii_frame_receiver_checksum (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [7:0]  m_body_byte,
    output logic [2:0]  m_status,
    output logic [15:0] m_computed_sum,
    output logic [15:0] m_received_sum,
    output logic [7:0]  m_body_count
);
    import afrc_pkg::*;

    item_t s_item;
    item_t item;
    res_t  res;
    res_t  m_res;
    logic  advance;
    logic  slot_free;
    logic  res_load;

    assign cfg_ready      = 1'b1;
    assign s_item.mode    = s_mode;
    assign s_item.rx_byte = s_rx_byte;

    afrc_in u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .slot_free (slot_free),
        .advance   (advance),
        .item      (item)
    );

    afrc_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .advance  (advance),
        .item     (item),
        .res_load (res_load),
        .res      (res)
    );

    afrc_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_load  (res_load),
        .res       (res),
        .slot_free (slot_free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_res     (m_res)
    );

    assign m_kind         = m_res.kind;
    assign m_body_byte    = m_res.body_byte;
    assign m_status       = m_res.status;
    assign m_computed_sum = m_res.computed_sum;
    assign m_received_sum = m_res.received_sum;
    assign m_body_count   = m_res.body_count;

endmodule
